// ===== hw/rtl/cpmm_pkg.sv =====
`timescale 1ns / 1ps

package cpmm_pkg;

    localparam int NUM_BODIES = 256;
    localparam int ID_W       = $clog2(NUM_BODIES);
    localparam int COMP_W     = 16;
    localparam int VEC_W      = 3 * COMP_W;
    localparam int PROD_W     = 33;

    localparam logic OP_MERGE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic accept;
        logic rd_b;
        logic upd_a;
        logic upd_b;
        logic clr_a;
        logic done;
    } cmd_t;

    typedef struct packed {
        logic is_read;
    } status_t;

endpackage

// ===== hw/rtl/contact_penetration_max_merge_top.sv =====
`timescale 1ns / 1ps
// merge word: accepted when start and not busy, done strobes via done register after MRG_A, MRG_B
// read-and-clear word: done strobes via the done register after state MRG_A
// no new word is accepted while busy; a merge is paced by the store doing
// read-modify-write on body a then body b
// reset clears all per-body valid bits, so every stored vector reads as zero

module contact_penetration_max_merge_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [7:0]         body_a,
    input  logic [7:0]         body_b,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic [15:0]        penetration,
    output logic               done,
    output logic signed [15:0] a_x,
    output logic signed [15:0] a_y,
    output logic signed [15:0] a_z,
    output logic signed [15:0] b_x,
    output logic signed [15:0] b_y,
    output logic signed [15:0] b_z
);
    import cpmm_pkg::*;

    cmd_t    cmd;
    status_t status;

    cpmm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    cpmm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .opcode      (opcode),
        .body_a      (body_a),
        .body_b      (body_b),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .normal_z    (normal_z),
        .penetration (penetration),
        .done        (done),
        .a_x         (a_x),
        .a_y         (a_y),
        .a_z         (a_z),
        .b_x         (b_x),
        .b_y         (b_y),
        .b_z         (b_z)
    );

endmodule

// ===== hw/rtl/cpmm_ctrl.sv =====
`timescale 1ns / 1ps

module cpmm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cpmm_pkg::status_t status,
    output cpmm_pkg::cmd_t    cmd,
    output logic              busy
);
    import cpmm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MRG_A = 3'b010,
        ST_MRG_B = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_MRG_A;
                end
            end
            ST_MRG_A:
            begin
                cmd.rd_b = 1'b1;
                if (status.is_read)
                begin
                    cmd.clr_a  = 1'b1;
                    cmd.done   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.upd_a  = 1'b1;
                    state_next = ST_MRG_B;
                end
            end
            ST_MRG_B:
            begin
                cmd.upd_b  = 1'b1;
                cmd.done   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== hw/rtl/cpmm_dp.sv =====
`timescale 1ns / 1ps

module cpmm_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  cpmm_pkg::cmd_t     cmd,
    output cpmm_pkg::status_t  status,
    input  logic               opcode,
    input  logic [7:0]         body_a,
    input  logic [7:0]         body_b,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic [15:0]        penetration,
    output logic               done,
    output logic signed [15:0] a_x,
    output logic signed [15:0] a_y,
    output logic signed [15:0] a_z,
    output logic signed [15:0] b_x,
    output logic signed [15:0] b_y,
    output logic signed [15:0] b_z
);
    import cpmm_pkg::*;

    function automatic logic signed [COMP_W-1:0] sat16(input logic signed [18:0] v);
        logic signed [COMP_W-1:0] r;
        if (v > 19'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -19'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[COMP_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [COMP_W:0] mag(input logic signed [COMP_W-1:0] v);
        logic signed [COMP_W:0] e;
        e = {v[COMP_W-1], v};
        return e[COMP_W] ? 17'(-e) : 17'(e);
    endfunction

    logic                     op_reg;
    logic [ID_W-1:0]          ida_reg;
    logic [ID_W-1:0]          idb_reg;
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [PROD_W-1:0] prod_next [3];

    logic [VEC_W-1:0]         mem [NUM_BODIES];
    logic [NUM_BODIES-1:0]    vld_reg;
    logic [VEC_W-1:0]         rdata_reg;
    logic                     rvld_reg;
    logic [ID_W-1:0]          raddr;
    logic [ID_W-1:0]          waddr;
    logic                     wen;

    logic [VEC_W-1:0]         cur_vec;
    logic [VEC_W-1:0]         new_vec;
    logic [VEC_W-1:0]         avec_reg;
    logic [VEC_W-1:0]         res_a_reg;
    logic [VEC_W-1:0]         res_b_reg;
    logic                     done_reg;

    always_comb
    begin
        prod_next[0] = PROD_W'($signed(normal_x)) * PROD_W'($signed({1'b0, penetration}));
        prod_next[1] = PROD_W'($signed(normal_y)) * PROD_W'($signed({1'b0, penetration}));
        prod_next[2] = PROD_W'($signed(normal_z)) * PROD_W'($signed({1'b0, penetration}));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= opcode;
            ida_reg  <= body_a[ID_W-1:0];
            idb_reg  <= body_b[ID_W-1:0];
            prod_reg <= prod_next;
        end
    end

    assign status.is_read = (op_reg == OP_READ);

    // store with one read port and one write port, read data registered
    assign raddr = cmd.rd_b ? idb_reg : body_a[ID_W-1:0];
    assign wen   = cmd.upd_a | cmd.upd_b;
    assign waddr = cmd.upd_b ? idb_reg : ida_reg;

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
        if (wen)
        begin
            mem[waddr] <= new_vec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            rvld_reg <= vld_reg[raddr];
            if (wen)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            else if (cmd.clr_a)
            begin
                vld_reg[ida_reg] <= 1'b0;
            end
        end
    end

    // same body twice: body b sees body a's fresh value
    always_comb
    begin
        if (cmd.upd_b && (idb_reg == ida_reg))
        begin
            cur_vec = avec_reg;
        end
        else
        begin
            cur_vec = rvld_reg ? rdata_reg : '0;
        end
    end

    always_comb
    begin
        logic signed [17:0]       h;
        logic signed [18:0]       hx;
        logic signed [COMP_W-1:0] cand;
        logic signed [COMP_W-1:0] cur;
        new_vec = '0;
        for (int k = 0; k < 3; k++)
        begin
            h    = prod_reg[k][PROD_W-1:15];
            hx   = {h[17], h};
            cand = cmd.upd_a ? sat16(-hx) : sat16(hx);
            cur  = cur_vec[k*COMP_W +: COMP_W];
            new_vec[k*COMP_W +: COMP_W] = (mag(cur) < mag(cand)) ? cand : cur;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd_a)
        begin
            avec_reg <= new_vec;
        end
        if (cmd.clr_a)
        begin
            res_a_reg <= cur_vec;
            res_b_reg <= '0;
        end
        else if (cmd.upd_b)
        begin
            res_a_reg <= avec_reg;
            res_b_reg <= new_vec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.done;
        end
    end

    assign done = done_reg;
    assign a_x  = res_a_reg[0*COMP_W +: COMP_W];
    assign a_y  = res_a_reg[1*COMP_W +: COMP_W];
    assign a_z  = res_a_reg[2*COMP_W +: COMP_W];
    assign b_x  = res_b_reg[0*COMP_W +: COMP_W];
    assign b_y  = res_b_reg[1*COMP_W +: COMP_W];
    assign b_z  = res_b_reg[2*COMP_W +: COMP_W];

endmodule
